// ----- rtl/core/fege_pkg.sv -----
`default_nettype none
package fege_pkg;

  // Default geometry and level limit
  localparam int GRID_W_DEF    = 128;
  localparam int GRID_H_DEF    = 128;
  localparam int LEVEL_MAX_DEF = 320;

  localparam int HEAT_W = 12;
  localparam int DISP_W = 9;
  localparam int LVL_W  = 9;
  localparam logic [HEAT_W-1:0] HEAT_SAT = 12'd4095;

  // Neighbor cells touched per lit cell
  localparam int NB_COUNT = 6;

  // Register reset values
  localparam logic [7:0] VSPREAD_RST  = 8'd78;
  localparam logic [7:0] HSPREAD_RST  = 8'd26;
  localparam logic [7:0] RESIDUAL_RST = 8'd68;
  localparam logic [3:0] TREND_RST    = 4'd2;

  typedef enum logic [1:0] {
    K_SEED      = 2'd0,
    K_PERTURB   = 2'd1,
    K_PROPAGATE = 2'd2,
    K_READ      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    R_VSPREAD  = 2'd0,
    R_HSPREAD  = 2'd1,
    R_RESIDUAL = 2'd2,
    R_TREND    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] column;
    logic [8:0] amount;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  op_done;
    logic [31:0] pixel_color;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SEED,
    S_PERT_RD,
    S_PERT_WR,
    S_CELL_RD,
    S_CELL_LD,
    S_MUL,
    S_NB_RD,
    S_NB_WR,
    S_WB,
    S_NEXT,
    S_RD_C,
    S_RD_O,
    S_RD_COL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic seed_wr;
    logic pert_rd;
    logic pert_wr;
    logic cell_rd;
    logic cell_ld;
    logic mul;
    logic nb_rd;
    logic nb_wr;
    logic cell_wb;
    logic step;
    logic rd_c;
    logic rd_o;
    logic color_calc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic  clr_last;
    kind_t kind;
    logic  cell_zero;
    logic  nb_last;
    logic  pass_last;
    logic  in_area;
    logic  out_busy;
  } stat_t;

  // Clamp to one color channel
  function automatic logic [7:0] ramp(input logic signed [11:0] v);
    if (v < 0) return 8'd0;
    if (v > 12'sd255) return 8'd255;
    return v[7:0];
  endfunction

  // Black, red, yellow, white ramp with opaque alpha
  function automatic logic [31:0] palette(input logic [LVL_W-1:0] i);
    logic signed [11:0] k;
    logic signed [11:0] gk;
    logic signed [11:0] bk;
    k  = $signed({3'b000, i});
    gk = k - 12'sd80;
    bk = k - 12'sd160;
    return {8'hFF, ramp(k + k + k), ramp(gk + gk + gk), ramp(bk + bk + bk)};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fege_ctrl.sv -----
`default_nettype none
module fege_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  fege_pkg::stat_t    stat,
  output fege_pkg::cmd_t     cmd
);
  import fege_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (stat.clr_last) state_next = S_IDLE;
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        unique case (stat.kind)
          K_SEED:      state_next = S_SEED;
          K_PERTURB:   state_next = S_PERT_RD;
          K_PROPAGATE: state_next = S_CELL_RD;
          default:     state_next = S_RD_C;
        endcase
      end
      S_SEED:     state_next = S_DONE;
      S_PERT_RD:  state_next = S_PERT_WR;
      S_PERT_WR:  state_next = S_DONE;
      S_CELL_RD:  state_next = S_CELL_LD;
      S_CELL_LD:  state_next = stat.cell_zero ? S_NEXT : S_MUL;
      S_MUL:      state_next = S_NB_RD;
      S_NB_RD:    state_next = S_NB_WR;
      S_NB_WR:    state_next = stat.nb_last ? S_WB : S_NB_RD;
      S_WB:       state_next = S_NEXT;
      S_NEXT:     state_next = stat.pass_last ? S_DONE : S_CELL_RD;
      S_RD_C:     state_next = stat.in_area ? S_RD_O : S_DONE;
      S_RD_O:     state_next = S_RD_COL;
      S_RD_COL:   state_next = S_DONE;
      S_DONE:     if (!stat.out_busy) state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLEAR:    cmd.clr_wr = 1'b1;
      S_IDLE:     cmd.load = in_valid;
      S_SEED:     cmd.seed_wr = 1'b1;
      S_PERT_RD:  cmd.pert_rd = 1'b1;
      S_PERT_WR:  cmd.pert_wr = 1'b1;
      S_CELL_RD:  cmd.cell_rd = 1'b1;
      S_CELL_LD:  cmd.cell_ld = 1'b1;
      S_MUL:      cmd.mul = 1'b1;
      S_NB_RD:    cmd.nb_rd = 1'b1;
      S_NB_WR:    cmd.nb_wr = 1'b1;
      S_WB:       cmd.cell_wb = 1'b1;
      S_NEXT:     cmd.step = 1'b1;
      S_RD_C:     cmd.rd_c = 1'b1;
      S_RD_O:     cmd.rd_o = 1'b1;
      S_RD_COL:   cmd.color_calc = 1'b1;
      S_DONE:     cmd.out_load = !stat.out_busy;
      default:    cmd = '0;
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/core/fege_dpath.sv -----
`default_nettype none
module fege_dpath #(
  parameter int GRID_W    = fege_pkg::GRID_W_DEF,
  parameter int GRID_H    = fege_pkg::GRID_H_DEF,
  parameter int LEVEL_MAX = fege_pkg::LEVEL_MAX_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  fege_pkg::in_item_t       in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output fege_pkg::out_item_t      out_data,
  input  wire logic                cfg_wr,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data,
  input  fege_pkg::cmd_t           cmd,
  output fege_pkg::stat_t          stat
);
  import fege_pkg::*;

  localparam int CELLS = GRID_W * GRID_H;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(GRID_W);
  localparam int YW    = $clog2(GRID_H);

  function automatic logic [AW-1:0] addr_of(input int unsigned yy, input int unsigned xx);
    return AW'(yy * GRID_W + xx);
  endfunction

  // Configuration registers
  logic [7:0] vspread;
  logic [7:0] hspread;
  logic [7:0] residual;
  logic [3:0] trend;

  always_ff @(posedge clk) begin
    if (rst) begin
      vspread  <= VSPREAD_RST;
      hspread  <= HSPREAD_RST;
      residual <= RESIDUAL_RST;
      trend    <= TREND_RST;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        R_VSPREAD:  vspread  <= cfg_data;
        R_HSPREAD:  hspread  <= cfg_data;
        R_RESIDUAL: residual <= cfg_data;
        R_TREND:    trend    <= cfg_data[3:0];
        default:    vspread  <= vspread;
      endcase
    end
  end

  // Request capture
  in_item_t req;
  always_ff @(posedge clk) begin
    if (cmd.load) req <= in_data;
  end

  // Counters
  logic [AW-1:0] clr_cnt;
  logic [XW-1:0] x_cnt;
  logic [YW-1:0] y_cnt;
  logic [2:0]    nb_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      x_cnt   <= XW'(1);
      y_cnt   <= YW'(GRID_H - 1);
      nb_idx  <= '0;
    end else begin
      if (cmd.clr_wr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.load) begin
        x_cnt <= XW'(1);
        y_cnt <= YW'(GRID_H - 1);
      end else if (cmd.step) begin
        if (x_cnt == XW'(GRID_W - 2)) begin
          x_cnt <= XW'(1);
          y_cnt <= y_cnt - 1'b1;
        end else begin
          x_cnt <= x_cnt + 1'b1;
        end
      end
      if (cmd.cell_ld)     nb_idx <= '0;
      else if (cmd.nb_wr)  nb_idx <= nb_idx + 1'b1;
    end
  end

  // Memories
  logic [HEAT_W-1:0] heat_mem [CELLS];
  logic [DISP_W-1:0] disp_mem [CELLS];
  logic [HEAT_W-1:0] heat_q;
  logic [DISP_W-1:0] disp_q;

  logic              hw_en;
  logic [AW-1:0]     hw_addr;
  logic [HEAT_W-1:0] hw_data;
  logic [AW-1:0]     hr_addr;
  logic              dw_en;
  logic [AW-1:0]     dw_addr;
  logic [DISP_W-1:0] dw_data;
  logic [AW-1:0]     dr_addr;

  // Cell values for the current pass
  logic [LVL_W-1:0] v_reg;
  logic             over;
  logic [LVL_W-1:0] tv;
  logic [LVL_W-1:0] th;
  logic [LVL_W-1:0] rr;

  logic [AW-1:0] bot_addr;
  logic [AW-1:0] ctr_addr;
  logic [AW-1:0] nb_addr;
  logic [LVL_W-1:0] nb_add;
  logic          col_ok;
  logic          bottom_row;

  assign col_ok     = int'(req.column) < GRID_W;
  assign bot_addr   = addr_of(GRID_H - 1, int'(req.column));
  assign ctr_addr   = addr_of(int'(y_cnt), int'(x_cnt));
  assign bottom_row = (y_cnt == YW'(GRID_H - 1));

  // Neighbor address and increment
  always_comb begin
    case (nb_idx)
      3'd0: begin
        nb_addr = addr_of(int'(y_cnt) - 2, int'(x_cnt));
        nb_add  = tv >> 1;
      end
      3'd1: begin
        nb_addr = addr_of(int'(y_cnt) - 1, int'(x_cnt));
        nb_add  = tv;
      end
      3'd2: begin
        nb_addr = addr_of(int'(y_cnt) - 1, int'(x_cnt) - 1);
        nb_add  = th;
      end
      3'd3: begin
        nb_addr = addr_of(int'(y_cnt) - 1, int'(x_cnt) + 1);
        nb_add  = th;
      end
      3'd4: begin
        nb_addr = addr_of(int'(y_cnt), int'(x_cnt) - 1);
        nb_add  = th >> 1;
      end
      default: begin
        nb_addr = addr_of(int'(y_cnt), int'(x_cnt) + 1);
        nb_add  = th >> 1;
      end
    endcase
  end

  // Saturating neighbor sum
  logic [HEAT_W:0]   nb_sum;
  logic [HEAT_W-1:0] nb_sat;
  assign nb_sum = {1'b0, heat_q} + {4'b0, nb_add};
  assign nb_sat = nb_sum[HEAT_W] ? HEAT_SAT : nb_sum[HEAT_W-1:0];

  // Perturb value
  logic signed [13:0] pv_s;
  logic [HEAT_W-1:0]  pv;
  assign pv_s = $signed({2'b00, heat_q}) + $signed({5'b0, req.amount})
              - $signed({10'b0, trend});
  assign pv   = (pv_s < 0 || pv_s > $signed(14'(LEVEL_MAX))) ? '0 : pv_s[11:0];

  // Heat write port
  always_comb begin
    hw_en   = 1'b0;
    hw_addr = nb_addr;
    hw_data = nb_sat;
    if (cmd.clr_wr) begin
      hw_en   = 1'b1;
      hw_addr = clr_cnt;
      hw_data = '0;
    end else if (cmd.seed_wr) begin
      hw_en   = col_ok;
      hw_addr = bot_addr;
      hw_data = {3'b0, req.amount};
    end else if (cmd.pert_wr) begin
      hw_en   = col_ok;
      hw_addr = bot_addr;
      hw_data = pv;
    end else if (cmd.nb_wr) begin
      hw_en   = 1'b1;
    end else if (cmd.cell_wb) begin
      hw_en   = !bottom_row || over;
      hw_addr = ctr_addr;
      hw_data = bottom_row ? {3'b0, v_reg} : {3'b0, rr};
    end
  end

  always_comb begin
    if (cmd.pert_rd)      hr_addr = bot_addr;
    else if (cmd.cell_rd) hr_addr = ctr_addr;
    else                  hr_addr = nb_addr;
  end

  // Pixel read coordinates
  logic [6:0] rx;
  logic [6:0] ry;
  logic       off00;
  assign rx    = req.pixel_x[7:1];
  assign ry    = req.pixel_y[7:1];
  assign off00 = !req.pixel_x[0] && !req.pixel_y[0];

  always_comb begin
    if (cmd.rd_c)               dr_addr = addr_of(int'(ry), int'(rx));
    else if (!req.pixel_y[0])   dr_addr = addr_of(int'(ry), int'(rx) + 1);
    else if (req.pixel_x[0])    dr_addr = addr_of(int'(ry) + 1, int'(rx) + 1);
    else                        dr_addr = addr_of(int'(ry) + 1, int'(rx));
  end

  // Display write port
  always_comb begin
    dw_en   = cmd.clr_wr || cmd.cell_wb;
    dw_addr = cmd.clr_wr ? clr_cnt : ctr_addr;
    dw_data = cmd.clr_wr ? '0 : v_reg;
  end

  always_ff @(posedge clk) begin
    if (hw_en) heat_mem[hw_addr] <= hw_data;
    heat_q <= heat_mem[hr_addr];
  end

  always_ff @(posedge clk) begin
    if (dw_en) disp_mem[dw_addr] <= dw_data;
    disp_q <= disp_mem[dr_addr];
  end

  // Clamp and spread products
  logic [16:0] pv_mul;
  logic [16:0] ph_mul;
  logic [16:0] pr_mul;
  assign pv_mul = {8'b0, v_reg} * {9'b0, vspread};
  assign ph_mul = {8'b0, v_reg} * {9'b0, hspread};
  assign pr_mul = {8'b0, v_reg} * {9'b0, residual};

  always_ff @(posedge clk) begin
    if (cmd.cell_ld) begin
      over  <= heat_q > HEAT_W'(LEVEL_MAX);
      v_reg <= (heat_q > HEAT_W'(LEVEL_MAX)) ? LVL_W'(LEVEL_MAX) : heat_q[LVL_W-1:0];
    end
    if (cmd.mul) begin
      tv <= pv_mul[16:8];
      th <= ph_mul[16:8];
      rr <= pr_mul[16:8];
    end
  end

  // Pixel color
  logic [DISP_W-1:0] c_q;
  logic [DISP_W:0]   idx_sum;
  logic [DISP_W:0]   idx_raw;
  logic [LVL_W-1:0]  idx;
  logic [31:0]       color_q;

  assign idx_sum = {1'b0, c_q} + {1'b0, disp_q};
  assign idx_raw = off00 ? {1'b0, c_q} : {1'b0, idx_sum[DISP_W:1]};
  assign idx     = (idx_raw > 10'(LEVEL_MAX - 1)) ? LVL_W'(LEVEL_MAX - 1)
                                                  : idx_raw[LVL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd_o) c_q <= disp_q;
    if (cmd.load)            color_q <= '0;
    else if (cmd.color_calc) color_q <= palette(idx);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.op_done     <= req.kind;
      out_data.pixel_color <= color_q;
    end
  end

  // Status
  always_comb begin
    stat.clr_last  = (clr_cnt == AW'(CELLS - 1));
    stat.kind      = kind_t'(req.kind);
    stat.cell_zero = (heat_q == '0);
    stat.nb_last   = (nb_idx == 3'(NB_COUNT - 1));
    stat.pass_last = (x_cnt == XW'(GRID_W - 2)) && (y_cnt == YW'(2));
    stat.in_area   = (int'(rx) < GRID_W - 1) && (int'(ry) < GRID_H - 1);
    stat.out_busy  = out_valid && out_stall;
  end

`ifndef SYNTHESIS
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    cmd.cell_ld |=> v_reg <= LVL_W'(LEVEL_MAX))
    else $error("cell value above level maximum");
  a_xrange: assert property (@(posedge clk) disable iff (rst)
    int'(x_cnt) >= 1 && int'(x_cnt) <= GRID_W - 2)
    else $error("column counter out of range");
  a_nonread: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.op_done != K_READ |-> out_data.pixel_color == '0)
    else $error("nonzero color on a non-read result");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/fire_effect_grid_engine_core.sv -----
`default_nettype none
// Seed writes the heat cell; perturb reads, then writes it; a pixel read takes one display read,
//   or two and the color inside the area. Propagate skips unlit cells of (GRID_H-2)*(GRID_W-2);
//   a lit one updates six neighbors, each read then written on the one heat read/write port.
// One request is in work at a time; a finished result waits in the output register.
// Reset (rst, synchronous): registers take their defaults, then a clearing pass zeroes all
//   GRID_W*GRID_H cells of both grids; requests are stalled until it ends.
module fire_effect_grid_engine_core #(
  parameter int GRID_W    = fege_pkg::GRID_W_DEF,
  parameter int GRID_H    = fege_pkg::GRID_H_DEF,
  parameter int LEVEL_MAX = fege_pkg::LEVEL_MAX_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  fege_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output fege_pkg::out_item_t  out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [7:0]      cfg_data
);
  import fege_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  fege_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fege_dpath #(
    .GRID_W    (GRID_W),
    .GRID_H    (GRID_H),
    .LEVEL_MAX (LEVEL_MAX)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire
